FILE: rtl/dhse_pkg.sv
// ----------------------------------------------------------------------------
// dhse_pkg
// Shared types and constants of the distance history speed estimator.
// ----------------------------------------------------------------------------
package dhse_pkg;

   localparam int HISTORY_DEPTH_DEF = 100;

   localparam int TIME_W   = 32;
   localparam int DIST_W   = 16;
   localparam int ACTION_W = 2;
   localparam int SPEED_W  = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [14:0] MIN_DISTANCE_RST     = 15'd15;
   localparam logic [14:0] DROP_LIMIT_RST       = 15'd12;
   localparam logic [15:0] DROP_WINDOW_RST      = 16'd2000;
   localparam logic [15:0] PERIOD_RST           = 16'd5000;
   localparam logic [15:0] STILL_TIMEOUT_RST    = 16'd3600;
   localparam logic [12:0] MAX_SPEED_RST        = 13'd800;

   // km/h tenths per (distance unit / ms)
   localparam logic [16:0] SPEED_SCALE = 17'd36000;
   localparam logic [16:0] SLOW_LIMIT  = 17'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_DISTANCE  = 3'd0,
      CSR_DROP_LIMIT    = 3'd1,
      CSR_DROP_WINDOW   = 3'd2,
      CSR_PERIOD        = 3'd3,
      CSR_STILL_TIMEOUT = 3'd4,
      CSR_MAX_SPEED     = 3'd5
   } csr_index_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_KEEP      = 2'd0,
      ACT_UNDEFINED = 2'd1,
      ACT_SPEED     = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EVAL,
      S_RD1,
      S_CHK1,
      S_RD2,
      S_CHK2,
      S_MUL_MAG,
      S_MUL_LO,
      S_CMP_LO,
      S_CMP_HI,
      S_DIV_START,
      S_DIV_WAIT,
      S_OUT
   } state_type;

endpackage

FILE: rtl/dhse_if.sv
// ----------------------------------------------------------------------------
// dhse request and response channels
// Valid/ready channels carrying one tick and one speed result.
// ----------------------------------------------------------------------------
interface dhse_req_if;
   logic                 valid;
   logic                 ready;
   logic [31:0]          time_ms;
   logic                 time_valid;
   logic                 fault;
   logic signed [15:0]   distance;

   modport source (output valid, time_ms, time_valid, fault, distance, input ready);
   modport sink   (input valid, time_ms, time_valid, fault, distance, output ready);
endinterface

interface dhse_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           action;
   logic signed [13:0]   speed_tenths;

   modport source (output valid, action, speed_tenths, input ready);
   modport sink   (input valid, action, speed_tenths, output ready);
endinterface

FILE: rtl/dhse_ram.sv
// ----------------------------------------------------------------------------
// dhse_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module dhse_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] write_addr,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_addr,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;
endmodule

FILE: rtl/dhse_div.sv
// ----------------------------------------------------------------------------
// dhse_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dhse_div #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         busy,
   output logic         done,
   output logic [W-1:0] quotient
);
   localparam int CNT_W = $clog2(W + 1);

   logic [W-1:0]   rem_ff, rem_in;
   logic [W-1:0]   quo_ff, quo_in;
   logic [W-1:0]   dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [W:0]     shifted;
   logic [W:0]     trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[W]) begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

FILE: rtl/distance_history_speed_estimator.sv
// Invalid, faulted, first or unchanged ticks, and changed ones at or below the minimum
// distance, go from S_EVAL straight to S_OUT. Other changed distances walk the history
// for the drop check and then the period, one RAM read per entry, then use the shared
// multiplier and the bit-serial divider. One tick is in work at a time.
// Reset: configuration registers take their default values and the history is empty;
// the history RAM has no clearing pass.
// ----------------------------------------------------------------------------
// distance_history_speed_estimator
// Speed from a ring of recorded (time, distance) changes, sequenced over one
// history RAM, one multiplier and one iterative divider.
// ----------------------------------------------------------------------------
module distance_history_speed_estimator #(
   parameter int HISTORY_DEPTH = dhse_pkg::HISTORY_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   dhse_req_if.sink                         req_bus,
   dhse_rsp_if.source                       rsp_bus,
   input  logic                             csr_write_enable,
   input  logic [dhse_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dhse_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import dhse_pkg::*;

   localparam int IDX_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int ENT_W = TIME_W + DIST_W;

   // configuration
   logic [14:0] min_distance_ff, drop_limit_ff;
   logic [15:0] drop_window_ff, period_ff, still_timeout_ff;
   logic [12:0] max_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_distance_ff  <= MIN_DISTANCE_RST;
         drop_limit_ff    <= DROP_LIMIT_RST;
         drop_window_ff   <= DROP_WINDOW_RST;
         period_ff        <= PERIOD_RST;
         still_timeout_ff <= STILL_TIMEOUT_RST;
         max_speed_ff     <= MAX_SPEED_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_MIN_DISTANCE:  min_distance_ff  <= csr_write_data[14:0];
            CSR_DROP_LIMIT:    drop_limit_ff    <= csr_write_data[14:0];
            CSR_DROP_WINDOW:   drop_window_ff   <= csr_write_data;
            CSR_PERIOD:        period_ff        <= csr_write_data;
            CSR_STILL_TIMEOUT: still_timeout_ff <= csr_write_data;
            CSR_MAX_SPEED:     max_speed_ff     <= csr_write_data[12:0];
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [TIME_W-1:0]        t_ff, t_in;
   logic                     tv_ff, tv_in, flt_ff, flt_in;
   logic signed [DIST_W-1:0] d_ff, d_in;
   logic [TIME_W-1:0]        t0_ff, t0_in;
   logic signed [DIST_W-1:0] d0_ff, d0_in;
   logic [TIME_W-1:0]        ms_ff, ms_in;
   logic                     neg_ff, neg_in;
   logic [16:0]              absd_ff, absd_in;
   logic [TIME_W-1:0]        mag_ff, mag_in;
   logic [48:0]              prod_ff;
   logic [1:0]               res_act_ff, res_act_in;
   logic signed [SPEED_W-1:0] res_spd_ff, res_spd_in;
   logic [1:0]               rsp_act_ff, rsp_act_in;
   logic signed [SPEED_W-1:0] rsp_spd_ff, rsp_spd_in;

   logic [TIME_W-1:0] mul_a;
   logic [16:0]       mul_b;

   logic             ram_we;
   logic [ENT_W-1:0] ram_rdata;
   logic [TIME_W-1:0]        rd_t;
   logic signed [DIST_W-1:0] rd_d;
   logic signed [16:0]       drop_diff, dlt;
   logic [TIME_W-1:0]        age;
   logic [IDX_W-1:0]         head_inc, ptr_dec, head_dec;
   logic                     last_step;

   logic              div_start, div_busy, div_done;
   logic [TIME_W-1:0] div_q;

   dhse_ram #(.WIDTH(ENT_W), .DEPTH(HISTORY_DEPTH)) u_hist (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (head_in),
      .write_data ({t_ff, d_ff}),
      .read_addr  (ptr_ff),
      .read_data  (ram_rdata)
   );

   dhse_div #(.W(TIME_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (ms_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   assign rd_t = ram_rdata[ENT_W-1:DIST_W];
   assign rd_d = $signed(ram_rdata[DIST_W-1:0]);
   assign drop_diff = {rd_d[DIST_W-1], rd_d} - {d0_ff[DIST_W-1], d0_ff};
   assign dlt       = {d0_ff[DIST_W-1], d0_ff} - {rd_d[DIST_W-1], rd_d};
   assign age       = t0_ff - rd_t;
   assign head_inc  = (head_ff == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec  = (head_in == '0) ? IDX_W'(HISTORY_DEPTH - 1) : head_in - 1'b1;
   assign ptr_dec   = (ptr_ff == '0) ? IDX_W'(HISTORY_DEPTH - 1) : ptr_ff - 1'b1;
   assign last_step = (step_ff + 1'b1) == count_ff;

   assign req_bus.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      head_in      = head_ff;
      ptr_in       = ptr_ff;
      t_in = t_ff; tv_in = tv_ff; flt_in = flt_ff; d_in = d_ff;
      t0_in        = t0_ff;
      d0_in        = d0_ff;
      ms_in        = ms_ff;
      neg_in       = neg_ff;
      absd_in      = absd_ff;
      mag_in       = mag_ff;
      res_act_in   = res_act_ff;
      res_spd_in   = res_spd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_spd_in   = rsp_spd_ff;
      ram_we       = 1'b0;
      div_start    = 1'b0;
      mul_a        = {15'd0, absd_ff};
      mul_b        = SPEED_SCALE;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               t_in     = req_bus.time_ms;
               tv_in    = req_bus.time_valid;
               flt_in   = req_bus.fault;
               d_in     = req_bus.distance;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            res_spd_in = '0;
            state_in   = S_OUT;
            if (!tv_ff) begin
               count_in   = '0;
               res_act_in = ACT_KEEP;
            end else if (flt_ff) begin
               count_in   = '0;
               res_act_in = ACT_UNDEFINED;
            end else if (count_ff == '0) begin
               ram_we     = 1'b1;
               t0_in      = t_ff;
               d0_in      = d_ff;
               count_in   = CNT_W'(1);
               res_act_in = ACT_KEEP;
            end else if (d0_ff != d_ff) begin
               head_in = head_inc;
               ram_we  = 1'b1;
               t0_in   = t_ff;
               d0_in   = d_ff;
               if (count_ff != CNT_W'(HISTORY_DEPTH)) begin
                  count_in = count_ff + 1'b1;
               end
               if (d_ff <= $signed({1'b0, min_distance_ff})) begin
                  count_in   = '0;
                  res_act_in = ACT_UNDEFINED;
               end else begin
                  ptr_in   = head_dec;
                  step_in  = CNT_W'(1);
                  state_in = S_RD1;
               end
            end else begin
               res_act_in = ((t_ff - t0_ff) > {16'd0, still_timeout_ff}) ? ACT_SPEED
                                                                          : ACT_KEEP;
            end
         end
         S_RD1: state_in = S_CHK1;
         S_CHK1: begin
            // drop check ends at a drop over the limit, the first entry outside the window or the oldest entry
            if (drop_diff > $signed({2'b00, drop_limit_ff})) begin
               count_in   = '0;
               res_act_in = ACT_UNDEFINED;
               res_spd_in = '0;
               state_in   = S_OUT;
            end else if (age > {16'd0, drop_window_ff} || last_step) begin
               ptr_in   = head_dec;
               step_in  = CNT_W'(1);
               state_in = S_RD2;
            end else begin
               ptr_in   = ptr_dec;
               step_in  = step_ff + 1'b1;
               state_in = S_RD1;
            end
         end
         S_RD2: state_in = S_CHK2;
         S_CHK2: begin
            ms_in = age;
            if (age > {16'd0, period_ff}) begin
               neg_in   = dlt[16];
               absd_in  = dlt[16] ? 17'(-dlt) : 17'(dlt);
               state_in = S_MUL_MAG;
            end else if (last_step) begin
               // oldest entry too young or exactly at period: zero or keep
               res_act_in = (age >= {16'd0, period_ff}) ? ACT_SPEED : ACT_KEEP;
               res_spd_in = '0;
               state_in   = S_OUT;
            end else begin
               ptr_in   = ptr_dec;
               step_in  = step_ff + 1'b1;
               state_in = S_RD2;
            end
         end
         S_MUL_MAG: begin
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            mag_in   = prod_ff[TIME_W-1:0];
            mul_a    = ms_ff;
            mul_b    = SLOW_LIMIT;
            state_in = S_CMP_LO;
         end
         S_CMP_LO: begin
            mul_a = ms_ff;
            mul_b = {4'd0, max_speed_ff};
            if ({17'd0, mag_ff} < prod_ff) begin
               res_act_in = ACT_SPEED;
               res_spd_in = '0;
               state_in   = S_OUT;
            end else begin
               state_in = S_CMP_HI;
            end
         end
         S_CMP_HI: begin
            if ({17'd0, mag_ff} > prod_ff) begin
               res_act_in = ACT_UNDEFINED;
               res_spd_in = '0;
               state_in   = S_OUT;
            end else begin
               state_in = S_DIV_START;
            end
         end
         S_DIV_START: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               res_act_in = ACT_SPEED;
               res_spd_in = neg_ff ? -$signed(div_q[SPEED_W-1:0])
                                   : $signed(div_q[SPEED_W-1:0]);
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_act_in   = res_act_ff;
               rsp_spd_in   = res_spd_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff    <= step_in;
      ptr_ff     <= ptr_in;
      t_ff       <= t_in;
      tv_ff      <= tv_in;
      flt_ff     <= flt_in;
      d_ff       <= d_in;
      t0_ff      <= t0_in;
      d0_ff      <= d0_in;
      ms_ff      <= ms_in;
      neg_ff     <= neg_in;
      absd_ff    <= absd_in;
      mag_ff     <= mag_in;
      prod_ff    <= mul_a * mul_b;
      res_act_ff <= res_act_in;
      res_spd_ff <= res_spd_in;
      rsp_act_ff <= rsp_act_in;
      rsp_spd_ff <= rsp_spd_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.action       = rsp_act_ff;
   assign rsp_bus.speed_tenths = rsp_spd_ff;

   a_div_done_waits: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV_WAIT)
      else $error("divider finished outside its wait state");

   a_wait_has_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_WAIT) |-> (div_busy || div_done))
      else $error("waiting on an idle divider");

   a_walk_needs_two: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK1 || state_ff == S_CHK2) |-> count_ff >= CNT_W'(2))
      else $error("history walk with fewer than two entries");

   a_accept_evals: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> state_ff == S_EVAL)
      else $error("accepted tick not evaluated");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("history count beyond depth");
endmodule
